[rtl/flo_pkg.sv]
// Shared types and constants of the ownership lock with FIFO wait queue.
`timescale 1ns / 1ps

package flo_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 8;

    localparam logic [1:0] OP_REQUEST = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_FLUSH   = 2'd2;
    localparam logic [1:0] OP_QUERY   = 2'd3;

    localparam logic [2:0] ST_OK              = 3'd0;
    localparam logic [2:0] ST_ALREADY_OWNER   = 3'd1;
    localparam logic [2:0] ST_ALREADY_PENDING = 3'd2;
    localparam logic [2:0] ST_QUEUE_FULL      = 3'd3;
    localparam logic [2:0] ST_NOT_PENDING     = 3'd4;

    localparam logic NK_GRANT = 1'b0;
    localparam logic NK_FLUSH = 1'b1;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] requester_id;
    } flo_req_t;

    typedef struct packed {
        logic [2:0] status;
        logic       notify_valid;
        logic [7:0] notify_id;
        logic       notify_kind;
        logic       is_owner;
        logic       owner_valid;
        logic [7:0] owner_id;
        logic [4:0] waiting_count;
        logic       last;
    } flo_rsp_t;

    // Broadcast command to every queue cell
    typedef struct packed {
        logic drop_match;   // drop the cell holding the search id, close the gap
        logic append;       // first empty cell takes the search id
    } flo_cell_cmd_t;

endpackage

[rtl/flo_cell.sv]
// One slot of the wait queue: holds an id, compares, shifts towards the head.
`timescale 1ns / 1ps

module flo_cell #(
    parameter int ID_BITS = flo_pkg::ID_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  flo_pkg::flo_cell_cmd_t cmd,
    input  logic [ID_BITS-1:0]    search_id,
    input  logic                  prev_valid,   // neighbour nearer the head
    input  logic                  next_valid,   // neighbour nearer the tail
    input  logic [ID_BITS-1:0]    next_id,
    input  logic                  shift_in,     // a slot at or before this one leaves
    output logic                  shift_out,
    output logic                  valid,
    output logic [ID_BITS-1:0]    id,
    output logic                  match
);

    logic               valid_reg;
    logic               valid_next;
    logic [ID_BITS-1:0] id_reg;
    logic [ID_BITS-1:0] id_next;

    assign match     = valid_reg && (id_reg == search_id);
    assign shift_out = shift_in || (cmd.drop_match && match);
    assign valid     = valid_reg;
    assign id        = id_reg;

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        if (shift_out)
        begin
            valid_next = next_valid;
            id_next    = next_id;
        end
        else if (cmd.append && prev_valid && !valid_reg)
        begin
            valid_next = 1'b1;
            id_next    = search_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

endmodule

[rtl/fifo_ownership_lock_core.sv]
// Top level of the exclusive-ownership lock with a FIFO wait queue.
// The result of a request is registered: it appears on rsp with done in the cycle after acceptance.
// Request, release and query are accepted back to back; start is ignored while busy.
// Flush with N > 0 waiters gives N results, one per cycle; busy stays high until the last.
// Flush length is set by the waiting count; the queue cell row pops one waiter per cycle.
// Reset: lock free, queue empty, no output; queue ids need no clearing.
`timescale 1ns / 1ps

module fifo_ownership_lock_core #(
    parameter int QUEUE_DEPTH = flo_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = flo_pkg::ID_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  flo_pkg::flo_req_t req,
    output logic              done,
    output flo_pkg::flo_rsp_t rsp
);

    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);
    localparam logic [CntW-1:0] CntOne  = CntW'(1);

    // Owner and queue bookkeeping
    logic                owner_valid_reg;
    logic                owner_valid_next;
    logic [ID_BITS-1:0]  owner_reg;
    logic [ID_BITS-1:0]  owner_next;
    logic [CntW-1:0]     count_reg;
    logic [CntW-1:0]     count_next;
    logic                busy_reg;
    logic                busy_next;
    logic                done_reg;
    logic                done_next;
    flo_pkg::flo_rsp_t   rsp_reg;
    flo_pkg::flo_rsp_t   rsp_next;

    // Cell row
    flo_pkg::flo_cell_cmd_t cmd;
    logic                   pop;
    logic [ID_BITS-1:0]     req_id;
    logic [QUEUE_DEPTH:0]   shift_chain;
    logic [QUEUE_DEPTH-1:0] cell_valid;
    logic [QUEUE_DEPTH-1:0] cell_match;
    logic [ID_BITS-1:0]     cell_id [QUEUE_DEPTH];
    logic                   any_match;
    logic [ID_BITS-1:0]     head_id;

    assign req_id         = ID_BITS'(req.requester_id);
    assign shift_chain[0] = pop;
    assign any_match      = |cell_match;
    assign head_id        = cell_id[0];

    // Cell 0 is the head; each cell takes its tail-side neighbour when it shifts
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic               prev_v;
        logic               next_v;
        logic [ID_BITS-1:0] next_i;

        if (i == 0)
        begin : g_head
            assign prev_v = 1'b1;
        end
        else
        begin : g_body
            assign prev_v = cell_valid[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign next_v = 1'b0;
            assign next_i = '0;
        end
        else
        begin : g_link
            assign next_v = cell_valid[i+1];
            assign next_i = cell_id[i+1];
        end

        flo_cell #(
            .ID_BITS(ID_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .search_id (req_id),
            .prev_valid(prev_v),
            .next_valid(next_v),
            .next_id   (next_i),
            .shift_in  (shift_chain[i]),
            .shift_out (shift_chain[i+1]),
            .valid     (cell_valid[i]),
            .id        (cell_id[i]),
            .match     (cell_match[i])
        );
    end

    // Decode the request, or advance the flush drain while busy
    always_comb
    begin
        owner_valid_next = owner_valid_reg;
        owner_next       = owner_reg;
        count_next       = count_reg;
        busy_next        = busy_reg;
        done_next        = 1'b0;
        pop              = 1'b0;
        cmd.drop_match   = 1'b0;
        cmd.append       = 1'b0;

        rsp_next              = '0;
        rsp_next.status       = flo_pkg::ST_OK;
        rsp_next.notify_kind  = flo_pkg::NK_GRANT;
        rsp_next.last         = 1'b1;

        if (busy_reg)
        begin
            // flush drain: drop the head waiter each cycle
            pop                  = 1'b1;
            done_next            = 1'b1;
            count_next           = count_reg - CntOne;
            busy_next            = (count_reg != CntOne);
            rsp_next.notify_valid = 1'b1;
            rsp_next.notify_id   = 8'(head_id);
            rsp_next.notify_kind = flo_pkg::NK_FLUSH;
            rsp_next.last        = (count_reg == CntOne);
        end
        else if (start)
        begin
            done_next = 1'b1;
            case (req.opcode)
                flo_pkg::OP_REQUEST:
                begin
                    if (!owner_valid_reg)
                    begin
                        owner_valid_next      = 1'b1;
                        owner_next            = req_id;
                        rsp_next.notify_valid = 1'b1;
                        rsp_next.notify_id    = 8'(req_id);
                        rsp_next.is_owner     = 1'b1;
                    end
                    else if (owner_reg == req_id)
                    begin
                        rsp_next.status   = flo_pkg::ST_ALREADY_OWNER;
                        rsp_next.is_owner = 1'b1;
                    end
                    else if (any_match)
                    begin
                        rsp_next.status = flo_pkg::ST_ALREADY_PENDING;
                    end
                    else if (count_reg >= CntFull)
                    begin
                        rsp_next.status = flo_pkg::ST_QUEUE_FULL;
                    end
                    else
                    begin
                        cmd.append = 1'b1;
                        count_next = count_reg + CntOne;
                    end
                end
                flo_pkg::OP_RELEASE:
                begin
                    if (owner_valid_reg && owner_reg == req_id)
                    begin
                        if (count_reg != '0)
                        begin
                            // hand ownership to the oldest waiter
                            pop                   = 1'b1;
                            owner_next            = head_id;
                            count_next            = count_reg - CntOne;
                            rsp_next.notify_valid = 1'b1;
                            rsp_next.notify_id    = 8'(head_id);
                            rsp_next.is_owner     = (head_id == req_id);
                        end
                        else
                        begin
                            owner_valid_next = 1'b0;
                            owner_next       = '0;
                        end
                    end
                    else if (any_match)
                    begin
                        cmd.drop_match = 1'b1;
                        count_next     = count_reg - CntOne;
                    end
                    else
                    begin
                        rsp_next.status = flo_pkg::ST_NOT_PENDING;
                    end
                end
                flo_pkg::OP_FLUSH:
                begin
                    owner_valid_next = 1'b0;
                    owner_next       = '0;
                    if (count_reg != '0)
                    begin
                        pop                   = 1'b1;
                        count_next            = count_reg - CntOne;
                        busy_next             = (count_reg != CntOne);
                        rsp_next.notify_valid = 1'b1;
                        rsp_next.notify_id    = 8'(head_id);
                        rsp_next.notify_kind  = flo_pkg::NK_FLUSH;
                        rsp_next.last         = (count_reg == CntOne);
                    end
                end
                default:
                begin
                    rsp_next.is_owner = owner_valid_reg && (owner_reg == req_id);
                end
            endcase
        end

        // state after this step, as reported
        rsp_next.owner_valid   = owner_valid_next;
        rsp_next.owner_id      = 8'(owner_next);
        rsp_next.waiting_count = 5'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_valid_reg <= 1'b0;
            owner_reg       <= '0;
            count_reg       <= '0;
            busy_reg        <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            owner_valid_reg <= owner_valid_next;
            owner_reg       <= owner_next;
            count_reg       <= count_next;
            busy_reg        <= busy_next;
            done_reg        <= done_next;
        end
    end

    // hold the result payload; only the strobe needs a reset
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule
